// ===== design/lrip_pkg.sv =====
// Shared types, widths and constants of the lidar range image projection pipeline.
`default_nettype none

package lrip_pkg;

	// integer square root, two radicand bits per cell
	localparam int SQ_W  = 36;
	localparam int RT_W  = 18;
	localparam int REM_W = 20;

	typedef struct packed {
		logic [SQ_W-1:0]  s;
		logic [REM_W-1:0] r;
		logic [RT_W-1:0]  f;
	} sqrt_t;

	// vectoring CORDIC, angle in microdegrees
	localparam int CD_STEPS = 24;
	localparam int CD_SCALE = 12;
	localparam int CD_W     = 34;
	localparam int ANG_W    = 30;
	localparam int SH_W     = 5;

	localparam logic signed [ANG_W-1:0] HALF_TURN = 30'sd180000000;

	localparam logic signed [ANG_W-1:0] ATAN_UDEG [CD_STEPS] = '{
		30'sd45000000, 30'sd26565051, 30'sd14036243, 30'sd7125016,
		30'sd3576334,  30'sd1789911,  30'sd895174,   30'sd447614,
		30'sd223811,   30'sd111906,   30'sd55953,    30'sd27976,
		30'sd13988,    30'sd6994,     30'sd3497,     30'sd1749,
		30'sd874,      30'sd437,      30'sd219,      30'sd109,
		30'sd55,       30'sd27,       30'sd14,       30'sd7
	};

	typedef struct packed {
		logic signed [CD_W-1:0]  x;
		logic signed [CD_W-1:0]  y;
		logic signed [ANG_W-1:0] z;
		logic                    zero;
	} cordic_t;

	// restoring divider, one quotient bit per cell
	localparam int DIV_N = 21;
	localparam int DIV_W = 20;

	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [DIV_N-1:0] nq;
	} div_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_USE_RING  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HORIZ_RES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_RES  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 3'd4;

endpackage

`default_nettype wire

// ===== design/lidar_range_image_projection.sv =====
// Top level: projects lidar points into range image cells through chains of cells.
//
//  channel  dir  signals                         contents
//  s_*      in   s_tvalid s_tready s_tdata[63:0]  one point
//  m_*      out  m_tvalid m_tready m_tdata[103:0] m_tuser  one result
//  cfg_*    in   cfg_valid cfg_ready cfg_index cfg_data    register write
//
// One item per cycle while the pipeline is not frozen; an accepted item enters s1, runs to
// s76, then loads the output register; the depth is set by the square root, CORDIC and
// divider chains.
// Reset loads the register defaults and empties the pipeline; there is no clearing pass.
// When the output register and the skid stage both hold items, the whole pipeline
// freezes and s_tready drops until m_tready frees a slot.
`default_nettype none

module lidar_range_image_projection #(
	parameter int ROWS = 16,
	parameter int COLS = 1800
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [63:0]  s_tdata,   // pos_x, pos_y, pos_z, ring, zero fill
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [103:0]      m_tdata,   // row, column, cell_index, range, out_x, out_y, out_z, zero fill
	output logic              m_tuser,   // valid_res
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [lrip_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [18:0]  cfg_data
);

	localparam int FW  = lrip_pkg::RT_W;
	localparam int CW  = lrip_pkg::CD_W;
	localparam int SC  = lrip_pkg::CD_SCALE;
	localparam int AW  = lrip_pkg::ANG_W;
	localparam int SHW = lrip_pkg::SH_W;
	localparam int NST = lrip_pkg::CD_STEPS;
	localparam int DN  = lrip_pkg::DIV_N;
	localparam int DW  = lrip_pkg::DIV_W;

	// stage register positions along the pipe
	localparam int IDX_SR = 21;
	localparam int IDX_P2 = 51;
	localparam int IDX_F1 = 73;
	localparam int D      = 76;

	localparam int HALF_COLS = COLS / 2;
	localparam logic signed [22:0] HALF_C   = 23'(HALF_COLS);
	localparam logic signed [22:0] COLS_C   = 23'(COLS);
	localparam logic [DN-1:0]      ROWS_Q   = DN'(ROWS);
	localparam logic [7:0]         ROWS_R   = 8'(ROWS);
	localparam logic [19:0]        COLS_M   = 20'(COLS);
	localparam logic [30:0]        RECIP    = 31'd1099511628; // ceil(2^41 / 2000)
	localparam logic signed [20:0] QUARTER  = 21'sd90000;

	typedef struct packed {
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [17:0] z;
		logic [6:0]         ring;
		logic [17:0]        rng;
		logic               rneg;
		logic               cneg;
	} side_t;

	typedef struct packed {
		logic               hit;
		logic [3:0]         row;
		logic [10:0]        column;
		logic [14:0]        cell_idx;
		logic [17:0]        rng;
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [17:0] z;
	} res_t;

	// configuration
	logic        use_ring_q;
	logic [18:0] hres_q;
	logic [16:0] vres_q;
	logic [16:0] bottom_q;
	logic [17:0] min_range_q;
	logic [18:0] hres_eff;
	logic [16:0] vres_eff;

	assign cfg_ready = 1'b1;
	assign hres_eff  = (hres_q == '0) ? 19'd1 : hres_q;
	assign vres_eff  = (vres_q == '0) ? 17'd1 : vres_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_ring_q  <= 1'b1;
			hres_q      <= 19'd200;
			vres_q      <= 17'd2000;
			bottom_q    <= 17'd15100;
			min_range_q <= 18'd256;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lrip_pkg::REG_USE_RING:  use_ring_q  <= cfg_data[0];
				lrip_pkg::REG_HORIZ_RES: hres_q      <= cfg_data;
				lrip_pkg::REG_VERT_RES:  vres_q      <= cfg_data[16:0];
				lrip_pkg::REG_BOTTOM:    bottom_q    <= cfg_data[16:0];
				lrip_pkg::REG_MIN_RANGE: min_range_q <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	// flow control
	logic en;
	logic arr;
	logic out_v_q, skid_v_q;
	res_t out_q, skid_q;
	logic vld_q [D];
	side_t side_q [D];
	side_t side_nxt [D];

	assign en       = !skid_v_q;
	assign s_tready = en;
	assign arr      = en && vld_q[D-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < D; k++) vld_q[k] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= s_tvalid;
			for (int k = 1; k < D; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	// front: squares and sums
	logic signed [17:0] px, py, pz;
	logic signed [35:0] xp, yp, zp;
	logic [34:0] xx_s1, yy_s1, zz_s1;
	logic [35:0] hsq_s2, zz_s2;
	logic [35:0] hsq_s3, tot_s3;

	assign px = s_tdata[17:0];
	assign py = s_tdata[35:18];
	assign pz = s_tdata[53:36];

	always_comb begin
		xp = px * px;
		yp = py * py;
		zp = pz * pz;
	end

	// square root chains: horizontal distance and range
	lrip_pkg::sqrt_t sq_h [FW+1];
	lrip_pkg::sqrt_t sq_r [FW+1];

	assign sq_h[0] = '{s: hsq_s3, r: '0, f: '0};
	assign sq_r[0] = '{s: tot_s3, r: '0, f: '0};

	for (genvar j = 0; j < FW; j++) begin : g_sqrt
		lrip_sqrt_cell u_h (.clk(clk), .en(en), .d(sq_h[j]), .q(sq_h[j+1]));
		lrip_sqrt_cell u_r (.clk(clk), .en(en), .d(sq_r[j]), .q(sq_r[j+1]));
	end

	// round to nearest: remainder above root means s > f*f + f
	logic [FW:0] hd_rnd, rng_rnd;
	always_comb begin
		hd_rnd  = {1'b0, sq_h[FW].f} + {{FW{1'b0}}, (sq_h[FW].r > {2'b00, sq_h[FW].f})};
		rng_rnd = {1'b0, sq_r[FW].f} + {{FW{1'b0}}, (sq_r[FW].r > {2'b00, sq_r[FW].f})};
	end

	logic [17:0] hd_s22;

	function automatic lrip_pkg::cordic_t cordic_prep(input logic signed [18:0] xv,
			input logic signed [18:0] yv);
		lrip_pkg::cordic_t  c;
		logic signed [CW-1:0] xs, ys;
		xs = {{(CW-19-SC){xv[18]}}, xv, {SC{1'b0}}};
		ys = {{(CW-19-SC){yv[18]}}, yv, {SC{1'b0}}};
		c.zero = (xv == '0) && (yv == '0);
		if (xv < 0) begin
			c.x = -xs;
			c.y = -ys;
			c.z = (yv >= 0) ? lrip_pkg::HALF_TURN : -lrip_pkg::HALF_TURN;
		end else begin
			c.x = xs;
			c.y = ys;
			c.z = '0;
		end
		return c;
	endfunction

	// CORDIC chains: elevation atan2(z, hd) and azimuth atan2(x, y)
	lrip_pkg::cordic_t cd_e [NST+1];
	lrip_pkg::cordic_t cd_a [NST+1];
	lrip_pkg::cordic_t cd_e_s23, cd_a_s23;

	assign cd_e[0] = cd_e_s23;
	assign cd_a[0] = cd_a_s23;

	for (genvar j = 0; j < NST; j++) begin : g_cordic
		lrip_cordic_cell u_e (.clk(clk), .en(en), .shift(SHW'(j)),
			.angle(lrip_pkg::ATAN_UDEG[j]), .d(cd_e[j]), .q(cd_e[j+1]));
		lrip_cordic_cell u_a (.clk(clk), .en(en), .shift(SHW'(j)),
			.angle(lrip_pkg::ATAN_UDEG[j]), .d(cd_a[j]), .q(cd_a[j+1]));
	end

	// microdegrees to millidegrees, half away from zero, by reciprocal multiply
	logic              neg_s48 [2];
	logic              zr_s48  [2];
	logic [29:0]       n_s48   [2];
	logic              neg_s49 [2];
	logic              zr_s49  [2];
	logic [60:0]       p_s49   [2];
	logic signed [19:0] mdeg_s50 [2];

	logic signed [AW-1:0] zin [2];
	logic                 zfl [2];
	logic [AW-1:0]        zab [2];
	logic [AW:0]          nsum [2];
	logic [18:0]          qang [2];

	always_comb begin
		zin[0] = cd_e[NST].z;
		zin[1] = cd_a[NST].z;
		zfl[0] = cd_e[NST].zero;
		zfl[1] = cd_a[NST].zero;
		for (int k = 0; k < 2; k++) begin
			zab[k]  = (zin[k] < 0) ? AW'(-zin[k]) : AW'(zin[k]);
			nsum[k] = {zab[k], 1'b0} + (AW+1)'(1000);
			qang[k] = p_s49[k][59:41];
		end
	end

	// row and column numerators
	logic signed [20:0] rn_s51, dc_s51;
	logic signed [20:0] elev_x, azim_x, bot_x;
	lrip_pkg::div_t     rdv_s52, cdv_s52;
	logic [20:0]        ra, ca;
	logic [21:0]        cnum;

	always_comb begin
		elev_x = 21'(mdeg_s50[0]);
		azim_x = 21'(mdeg_s50[1]);
		bot_x  = $signed({4'b0000, bottom_q});
		ra     = (rn_s51 < 0) ? 21'(-rn_s51) : 21'(rn_s51);
		ca     = (dc_s51 < 0) ? 21'(-dc_s51) : 21'(dc_s51);
		cnum   = {ca, 1'b0} + {3'b000, hres_eff};
	end

	// dividers
	lrip_pkg::div_t rd [DN+1];
	lrip_pkg::div_t cd [DN+1];
	logic [DW-1:0]  vden, hden;

	assign vden  = {{(DW-17){1'b0}}, vres_eff};
	assign hden  = {hres_eff, 1'b0};
	assign rd[0] = rdv_s52;
	assign cd[0] = cdv_s52;

	for (genvar j = 0; j < DN; j++) begin : g_div
		lrip_div_cell u_r (.clk(clk), .en(en), .den(vden), .d(rd[j]), .q(rd[j+1]));
		lrip_div_cell u_c (.clk(clk), .en(en), .den(hden), .d(cd[j]), .q(cd[j+1]));
	end

	// finish: row, column, checks, cell index
	logic [6:0]         row_s74, row_s75;
	logic               rok_s74, ok_s75;
	logic signed [22:0] col_s74;
	logic [11:0]        col_s75;
	res_t               res_s76;
	logic signed [22:0] col_w;
	logic [19:0]        cell_full;
	logic [DN-1:0]      qr, qc;

	always_comb begin
		qr    = rd[DN].nq;
		qc    = cd[DN].nq;
		col_w = (col_s74 >= COLS_C) ? col_s74 - COLS_C : col_s74;
		cell_full = {13'b0, row_s75} * COLS_M + {8'b0, col_s75};
	end

	// side line carries the point, then range and signs
	always_comb begin
		side_nxt[0] = '{x: px, y: py, z: pz, ring: s_tdata[60:54], rng: '0,
			rneg: 1'b0, cneg: 1'b0};
		for (int k = 1; k < D; k++) side_nxt[k] = side_q[k-1];
		side_nxt[IDX_SR].rng  = rng_rnd[17:0];
		side_nxt[IDX_P2].rneg = rn_s51 < 0;
		side_nxt[IDX_P2].cneg = dc_s51 < 0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < D; k++) side_q[k] <= side_nxt[k];

			xx_s1  <= xp[34:0];
			yy_s1  <= yp[34:0];
			zz_s1  <= zp[34:0];
			hsq_s2 <= {1'b0, xx_s1} + {1'b0, yy_s1};
			zz_s2  <= {1'b0, zz_s1};
			hsq_s3 <= hsq_s2;
			tot_s3 <= hsq_s2 + zz_s2;

			hd_s22 <= hd_rnd[17:0];

			cd_e_s23 <= cordic_prep({1'b0, hd_s22},
				{side_q[IDX_SR].z[17], side_q[IDX_SR].z});
			cd_a_s23 <= cordic_prep({side_q[IDX_SR].y[17], side_q[IDX_SR].y},
				{side_q[IDX_SR].x[17], side_q[IDX_SR].x});

			for (int k = 0; k < 2; k++) begin
				neg_s48[k]  <= zin[k] < 0;
				zr_s48[k]   <= zfl[k];
				n_s48[k]    <= nsum[k][29:0];
				neg_s49[k]  <= neg_s48[k];
				zr_s49[k]   <= zr_s48[k];
				p_s49[k]    <= n_s48[k] * RECIP;
				if (zr_s49[k]) mdeg_s50[k] <= '0;
				else if (neg_s49[k]) mdeg_s50[k] <= -$signed({1'b0, qang[k]});
				else mdeg_s50[k] <= $signed({1'b0, qang[k]});
			end

			rn_s51 <= elev_x + bot_x;
			dc_s51 <= azim_x - QUARTER;

			rdv_s52 <= '{rem: '0, nq: ra};
			cdv_s52 <= '{rem: '0, nq: cnum[20:0]};

			if (use_ring_q) begin
				row_s74 <= side_q[IDX_F1-1].ring;
				rok_s74 <= {1'b0, side_q[IDX_F1-1].ring} < ROWS_R;
			end else begin
				row_s74 <= qr[6:0];
				rok_s74 <= (qr < ROWS_Q) && (!side_q[IDX_F1-1].rneg || qr == '0);
			end
			if (side_q[IDX_F1-1].cneg) col_s74 <= HALF_C + $signed({2'b00, qc});
			else col_s74 <= HALF_C - $signed({2'b00, qc});

			row_s75 <= row_s74;
			col_s75 <= col_w[11:0];
			ok_s75  <= rok_s74 && (col_w >= 0) && (col_w < COLS_C)
				&& (side_q[IDX_F1].rng >= min_range_q);

			if (ok_s75) begin
				res_s76 <= '{hit: 1'b1, row: row_s75[3:0], column: col_s75[10:0],
					cell_idx: cell_full[14:0], rng: side_q[IDX_F1+1].rng,
					x: side_q[IDX_F1+1].x, y: side_q[IDX_F1+1].y,
					z: side_q[IDX_F1+1].z};
			end else begin
				res_s76 <= '0;
			end
		end
	end

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= arr;
			end
		end else if (arr) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			if (skid_v_q) out_q <= skid_q;
			else if (arr) out_q <= res_s76;
		end else if (arr) begin
			skid_q <= res_s76;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.hit;
	assign m_tdata  = {2'b00, out_q.z, out_q.y, out_q.x, out_q.rng, out_q.cell_idx,
		out_q.column, out_q.row};

	// skid only fills behind a stalled output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds an item while output is empty");

	a_skid_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_tready))
		else $error("skid loaded without output stall");

	a_discard_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("discarded item carries nonzero fields");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (32'(m_tdata[14:4]) < COLS))
		else $error("column outside image");

endmodule

`default_nettype wire

// ===== design/lrip_sqrt_cell.sv =====
// One digit step of the pipelined integer square root.
`default_nettype none

module lrip_sqrt_cell (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire lrip_pkg::sqrt_t d,
	output lrip_pkg::sqrt_t     q
);

	localparam int SW = lrip_pkg::SQ_W;
	localparam int RW = lrip_pkg::REM_W;
	localparam int FW = lrip_pkg::RT_W;

	logic [RW+1:0]   r2;
	logic [RW+1:0]   t;
	logic [RW+1:0]   diff;
	logic            ge;
	lrip_pkg::sqrt_t nxt;

	always_comb begin
		r2   = {d.r, d.s[SW-1 -: 2]};
		t    = {2'b00, d.f, 2'b01};
		ge   = r2 >= t;
		diff = r2 - t;
		nxt.s = {d.s[SW-3:0], 2'b00};
		nxt.r = ge ? diff[RW-1:0] : r2[RW-1:0];
		nxt.f = {d.f[FW-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) q <= nxt;
	end

endmodule

`default_nettype wire

// ===== design/lrip_cordic_cell.sv =====
// One micro-rotation of the vectoring CORDIC.
`default_nettype none

module lrip_cordic_cell (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic [lrip_pkg::SH_W-1:0]         shift,
	input  wire logic signed [lrip_pkg::ANG_W-1:0] angle,
	input  wire lrip_pkg::cordic_t                 d,
	output lrip_pkg::cordic_t                      q
);

	localparam int CW = lrip_pkg::CD_W;

	logic signed [CW-1:0] x, y, xs, ys;
	lrip_pkg::cordic_t    nxt;

	always_comb begin
		x  = d.x;
		y  = d.y;
		xs = x >>> shift;
		ys = y >>> shift;
		nxt.zero = d.zero;
		if (y > 0) begin
			nxt.x = x + ys;
			nxt.y = y - xs;
			nxt.z = d.z + angle;
		end else begin
			nxt.x = x - ys;
			nxt.y = y + xs;
			nxt.z = d.z - angle;
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nxt;
	end

endmodule

`default_nettype wire

// ===== design/lrip_div_cell.sv =====
// One quotient bit of the pipelined restoring divider.
`default_nettype none

module lrip_div_cell (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [lrip_pkg::DIV_W-1:0]  den,
	input  wire lrip_pkg::div_t              d,
	output lrip_pkg::div_t                   q
);

	localparam int N = lrip_pkg::DIV_N;
	localparam int W = lrip_pkg::DIV_W;

	logic [W:0]     t;
	logic [W:0]     diff;
	logic           ge;
	lrip_pkg::div_t nxt;

	always_comb begin
		t    = {d.rem, d.nq[N-1]};
		ge   = t >= {1'b0, den};
		diff = t - {1'b0, den};
		nxt.rem = ge ? diff[W-1:0] : t[W-1:0];
		nxt.nq  = {d.nq[N-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) q <= nxt;
	end

endmodule

`default_nettype wire
